>>> hdl/trs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the term relevance scorer.
// No dependencies; imported by term_relevance_scorer and trs_log2.
package trs_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int FIELD_W        = 24;
    localparam int TOTAL_W        = 24;
    localparam int AVG_W          = 32;
    localparam int SCORE_W        = 38;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int FRAC_LOG       = 24;
    localparam int RQ_W           = 18;

    localparam logic [31:0]        LN2_Q32       = 32'hB172_17F8;
    localparam logic [23:0]        K_SCALE       = 24'd12582912;
    localparam logic [17:0]        R_SCALE       = 18'd163840;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = 38'h1F_FFFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_MIN_MAG = 38'h20_0000_0000;

    localparam logic MODE_BM25  = 1'b0;
    localparam logic MODE_TFIDF = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_MODE     = 2'd0,
        REG_TOTAL_DOCS     = 2'd1,
        REG_AVG_DOC_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic mode;
        logic zero;
        logic flag;
    } side_t;

endpackage

>>> hdl/term_relevance_scorer.sv
`timescale 1ns / 1ps
// Top level of the term relevance scorer: entry stage, log, divider and score pipelines.
// Depends on trs_pkg, trs_delay, trs_log2 and trs_div.
//
// Usage:
//   Write score_mode, total_docs and avg_doc_length through the cfg port
//   (cfg_ready is always high) while no item is in flight.
//   An item is taken at each rising edge with start high and busy low; busy
//   stays low, so one item may enter every cycle.
//   Each item gives one result: done is high for one cycle with score and
//   count_error. Results leave in entry order.
//   The latency is set by the TF-IDF path: 24 squaring stages of the log unit,
//   then one divider stage per quotient bit of tf*idf / ((len+1)*256).
//   Throughput is one item per cycle in either mode.
//   The receiver cannot stall: every done pulse is a transfer.
//   Reset clears the configuration and control registers to zero and drops every item in flight.
module term_relevance_scorer #(
    parameter int COUNT_BITS = trs_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [trs_pkg::FIELD_W-1:0]          term_freq,
    input  logic [trs_pkg::FIELD_W-1:0]          doc_length,
    input  logic [trs_pkg::FIELD_W-1:0]          docs_with_term,
    output logic                                 done,
    output logic signed [trs_pkg::SCORE_W-1:0]   score,
    output logic                                 count_error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [trs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import trs_pkg::*;

    localparam int CB      = COUNT_BITS;
    localparam int ARG_W   = CB + 1;
    localparam int LOG_W   = $clog2(ARG_W) + FRAC_LOG;
    localparam int KNUM_W  = CB + 24;
    localparam int KDEN_W  = AVG_W + 1;
    localparam int KQ_W    = CB + 16;
    localparam int D_W     = CB + 18;
    localparam int RNUM_W  = CB + 18;
    localparam int TNUM_W  = CB + LOG_W;
    localparam int TDEN_W  = CB + 9;
    localparam int TQ_W    = CB + LOG_W - 8;
    localparam int PROD_W  = LOG_W + 32;
    localparam int BMP_W   = RQ_W + LOG_W;
    localparam int BM_W    = BMP_W - FRAC_LOG;
    localparam int MAG_W   = (TQ_W > SCORE_W) ? TQ_W : SCORE_W;
    localparam int LOG_LAT = FRAC_LOG + 1;
    localparam int T_IDF   = LOG_LAT + 3;
    localparam int T_R     = 3 + KQ_W + RQ_W;
    localparam int T_BM    = T_R + 1;
    localparam int T_TF    = T_IDF + 1 + TQ_W;
    localparam int LATENCY = T_TF + 3;

    // configuration
    logic               score_mode_reg;
    logic [TOTAL_W-1:0] total_docs_reg;
    logic [AVG_W-1:0]   avg_doc_length_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_mode_reg     <= 1'b0;
            total_docs_reg     <= '0;
            avg_doc_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCORE_MODE:     score_mode_reg     <= cfg_data[0];
                REG_TOTAL_DOCS:     total_docs_reg     <= cfg_data[TOTAL_W-1:0];
                REG_AVG_DOC_LENGTH: avg_doc_length_reg <= cfg_data[AVG_W-1:0];
                default:            ;
            endcase
        end
    end

    // entry stage
    logic          accept;
    logic [CB-1:0] tf_c, len_c, n_c, bign_c, diff_c;
    logic          zero_c, over_c;
    side_t         s1_side_next, s1_side_reg;
    logic [ARG_W-1:0] s1_arg_a_reg, s1_arg_b_reg;
    logic [CB-1:0] s1_tf_reg, s1_len_reg;

    assign accept = start && !busy;
    assign tf_c   = CB'({8'b0, term_freq});
    assign len_c  = CB'({8'b0, doc_length});
    assign n_c    = CB'({8'b0, docs_with_term});
    assign bign_c = CB'({8'b0, total_docs_reg});
    assign zero_c = (bign_c == '0) || (n_c == '0);
    assign over_c = n_c > bign_c;
    assign diff_c = over_c ? '0 : bign_c - n_c;

    always_comb
    begin
        s1_side_next.valid = accept;
        s1_side_next.mode  = score_mode_reg;
        s1_side_next.zero  = zero_c;
        s1_side_next.flag  = (score_mode_reg == MODE_BM25) && !zero_c && over_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
        end
        else
        begin
            s1_side_reg <= s1_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_arg_a_reg <= (score_mode_reg == MODE_TFIDF) ? {1'b0, bign_c} : {diff_c, 1'b1};
        s1_arg_b_reg <= (score_mode_reg == MODE_TFIDF) ? {1'b0, n_c} : {n_c, 1'b1};
        s1_tf_reg    <= tf_c;
        s1_len_reg   <= len_c;
    end

    // log ratio path
    logic [LOG_W-1:0]  log_a, log_b;
    logic [LOG_W-1:0]  l1_diff_reg;
    logic              l1_neg_reg;
    logic [PROD_W-1:0] l2_prod_reg;
    logic              l2_neg_reg;
    logic [PROD_W:0]   l2_round;
    logic [LOG_W-1:0]  idf_next, idf_reg;
    logic              idf_neg_reg;

    trs_log2 #(.ARG_W(ARG_W), .LOG_W(LOG_W)) u_log_a (
        .clk     (clk),
        .arg     (s1_arg_a_reg),
        .log_val (log_a)
    );

    trs_log2 #(.ARG_W(ARG_W), .LOG_W(LOG_W)) u_log_b (
        .clk     (clk),
        .arg     (s1_arg_b_reg),
        .log_val (log_b)
    );

    assign l2_round = {1'b0, l2_prod_reg} + (PROD_W+1)'(33'h0_8000_0000);
    assign idf_next = l2_round[PROD_W-1:32];

    always_ff @(posedge clk)
    begin
        l1_neg_reg  <= log_a < log_b;
        l1_diff_reg <= (log_a < log_b) ? log_b - log_a : log_a - log_b;
        l2_prod_reg <= PROD_W'(l1_diff_reg) * PROD_W'(LN2_Q32);
        l2_neg_reg  <= l1_neg_reg;
        idf_reg     <= idf_next;
        idf_neg_reg <= l2_neg_reg && (idf_next != '0);
    end

    // BM25 length and frequency path
    logic [KNUM_W-1:0] knum_reg;
    logic [KDEN_W-1:0] kden_reg;
    logic [KQ_W-1:0]   kq;
    logic [CB-1:0]     tf_k, tf_k2_reg;
    logic [KQ_W-1:0]   k_reg;
    logic [RNUM_W-1:0] rnum_reg, rnum3_reg;
    logic [D_W-1:0]    k3;
    logic [D_W-1:0]    d_reg;
    logic [RQ_W-1:0]   rq;
    logic [LOG_W-1:0]  idf_bm;
    logic [BMP_W-1:0]  bm_prod_reg;
    logic [BM_W-1:0]   bm_mag_d;

    always_ff @(posedge clk)
    begin
        knum_reg <= KNUM_W'(K_SCALE) * KNUM_W'(s1_len_reg);
        kden_reg <= KDEN_W'(avg_doc_length_reg) + KDEN_W'(256);
    end

    trs_div #(.NUM_W(KNUM_W), .DEN_W(KDEN_W), .Q_W(KQ_W)) u_div_k (
        .clk (clk),
        .num (knum_reg),
        .den (kden_reg),
        .quo (kq)
    );

    trs_delay #(.WIDTH(CB), .DEPTH(1 + KQ_W)) u_dly_tf_k (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (s1_tf_reg),
        .dout  (tf_k)
    );

    assign k3 = D_W'(k_reg) + D_W'({k_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        k_reg     <= kq + KQ_W'(16384);
        rnum_reg  <= RNUM_W'(tf_k) * RNUM_W'(R_SCALE);
        tf_k2_reg <= tf_k;
        d_reg     <= D_W'({tf_k2_reg, 16'b0}) + (k3 >> 1);
        rnum3_reg <= rnum_reg;
    end

    trs_div #(.NUM_W(RNUM_W + 16), .DEN_W(D_W), .Q_W(RQ_W)) u_div_r (
        .clk (clk),
        .num ({rnum3_reg, 16'b0}),
        .den (d_reg),
        .quo (rq)
    );

    trs_delay #(.WIDTH(LOG_W), .DEPTH(T_R - T_IDF)) u_dly_idf (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (idf_reg),
        .dout  (idf_bm)
    );

    always_ff @(posedge clk)
    begin
        bm_prod_reg <= BMP_W'(rq) * BMP_W'(idf_bm);
    end

    trs_delay #(.WIDTH(BM_W), .DEPTH(T_TF - T_BM)) u_dly_bm (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (bm_prod_reg[BMP_W-1:FRAC_LOG]),
        .dout  (bm_mag_d)
    );

    // TF-IDF path
    logic [CB-1:0]     tf_t, len_t;
    logic [CB:0]       len_p1;
    logic [TNUM_W-1:0] t_prod_reg;
    logic [TDEN_W-1:0] t_den_reg;
    logic [TQ_W-1:0]   tf_mag;

    trs_delay #(.WIDTH(2 * CB), .DEPTH(T_IDF)) u_dly_tl (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({s1_tf_reg, s1_len_reg}),
        .dout  ({tf_t, len_t})
    );

    assign len_p1 = {1'b0, len_t} + (CB+1)'(1);

    always_ff @(posedge clk)
    begin
        t_prod_reg <= TNUM_W'(tf_t) * TNUM_W'(idf_reg);
        t_den_reg  <= {len_p1, 8'b0};
    end

    trs_div #(.NUM_W(TNUM_W), .DEN_W(TDEN_W), .Q_W(TQ_W)) u_div_t (
        .clk (clk),
        .num (t_prod_reg),
        .den (t_den_reg),
        .quo (tf_mag)
    );

    // final select, sign and saturate
    side_t              side_d;
    logic               neg_d;
    logic [MAG_W-1:0]   mag_sel;
    logic               f1_valid_reg;
    logic [MAG_W-1:0]   f1_mag_reg;
    logic               f1_neg_reg;
    logic               f1_flag_reg;
    logic [MAG_W-1:0]   mag_clip;
    logic [SCORE_W-1:0] score_next, score_reg;
    logic               done_reg, count_error_reg;

    trs_delay #(.WIDTH($bits(side_t)), .DEPTH(T_TF)) u_dly_side (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (s1_side_reg),
        .dout  (side_d)
    );

    trs_delay #(.WIDTH(1), .DEPTH(T_TF - T_IDF)) u_dly_neg (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (idf_neg_reg),
        .dout  (neg_d)
    );

    always_comb
    begin
        mag_sel = '0;
        if (!side_d.zero)
        begin
            mag_sel = (side_d.mode == MODE_TFIDF) ? MAG_W'(tf_mag) : MAG_W'(bm_mag_d);
        end
    end

    always_comb
    begin
        mag_clip = f1_mag_reg;
        if (f1_neg_reg)
        begin
            if (f1_mag_reg > MAG_W'(SCORE_MIN_MAG))
            begin
                mag_clip = MAG_W'(SCORE_MIN_MAG);
            end
            score_next = SCORE_W'(0) - mag_clip[SCORE_W-1:0];
        end
        else
        begin
            score_next = (f1_mag_reg > MAG_W'(SCORE_MAX)) ? SCORE_MAX
                                                          : f1_mag_reg[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= side_d.valid;
            done_reg     <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_mag_reg      <= mag_sel;
        f1_neg_reg      <= !side_d.zero && neg_d && (mag_sel != '0);
        f1_flag_reg     <= side_d.flag;
        score_reg       <= score_next;
        count_error_reg <= f1_flag_reg;
    end

    assign done        = done_reg;
    assign score       = $signed(score_reg);
    assign count_error = count_error_reg;

`ifndef ASSERT_OFF
    a_flag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && count_error |-> score[SCORE_W-1] || score == '0)
        else $error("saturated count gave a positive score");

    a_zero_tf: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(term_freq == '0, LATENCY) |-> score == '0)
        else $error("zero term frequency gave a nonzero score");

    a_zero_n: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(docs_with_term == '0, LATENCY) |-> score == '0 && !count_error)
        else $error("unused term gave a nonzero result");
`endif

endmodule

>>> hdl/trs_delay.sv
`timescale 1ns / 1ps
// Fixed-depth shift line that aligns side data with the arithmetic stages.
// Depends on nothing.
module trs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

>>> hdl/trs_log2.sv
`timescale 1ns / 1ps
// Pipelined fixed-point log2: normalize stage, then one squaring stage per fraction bit.
// Depends on trs_pkg.
module trs_log2 #(
    parameter int ARG_W = 25,
    parameter int LOG_W = 29
) (
    input  logic             clk,
    input  logic [ARG_W-1:0] arg,
    output logic [LOG_W-1:0] log_val
);
    import trs_pkg::*;

    localparam int POS_W = LOG_W - FRAC_LOG;

    logic [POS_W-1:0]    pos;
    logic [ARG_W-1:0]    arg_sh;
    logic [ARG_W+31:0]   arg_ext;

    logic [31:0]         mant_reg [0:FRAC_LOG];
    logic [FRAC_LOG-1:0] frac_reg [0:FRAC_LOG];
    logic [POS_W-1:0]    pos_reg  [0:FRAC_LOG];

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < ARG_W; i++)
        begin
            if (arg[i])
            begin
                pos = POS_W'(i);
            end
        end
        arg_sh  = arg << (POS_W'(ARG_W - 1) - pos);
        arg_ext = {arg_sh, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        mant_reg[0] <= arg_ext[ARG_W+31 -: 32];
        frac_reg[0] <= '0;
        pos_reg[0]  <= pos;
    end

    for (genvar s = 0; s < FRAC_LOG; s++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] sq_sh;

        assign sq    = 64'(mant_reg[s]) * 64'(mant_reg[s]);
        assign sq_sh = sq[63:31];

        always_ff @(posedge clk)
        begin
            mant_reg[s+1] <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            frac_reg[s+1] <= {frac_reg[s][FRAC_LOG-2:0], sq_sh[32]};
            pos_reg[s+1]  <= pos_reg[s];
        end
    end

    assign log_val = {pos_reg[FRAC_LOG], frac_reg[FRAC_LOG]};

endmodule

>>> hdl/trs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den * 2^Q_W. Depends on nothing.
module trs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 40
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   low_reg [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg [0:Q_W-1];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   trial_sub;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in = DEN_W'(num >> Q_W);
            assign den_in = den;
            assign low_in = num[Q_W-1:0];
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign low_in = low_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial     = {rem_in, low_in[Q_W-1]};
        assign trial_sub = trial - {1'b0, den_in};
        assign ge        = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            den_reg[s] <= den_in;
            low_reg[s] <= {low_in[Q_W-2:0], 1'b0};
            quo_reg[s] <= {quo_in[Q_W-2:0], ge};
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule
